/* rtl/bdqs_pkg.sv */
// Package: opcode and status codes, payload types for the deque block.
`timescale 1ns / 1ps
`default_nettype none

package bdqs_pkg;

  typedef logic [2:0]         opcode_t;
  typedef logic [1:0]         status_t;
  typedef logic signed [31:0] data_t;
  typedef logic [4:0]         pos_t;

  localparam opcode_t OP_PUSH_FRONT = 3'd0;
  localparam opcode_t OP_PUSH_BACK  = 3'd1;
  localparam opcode_t OP_POP_FRONT  = 3'd2;
  localparam opcode_t OP_POP_BACK   = 3'd3;
  localparam opcode_t OP_SEARCH     = 3'd4;
  localparam opcode_t OP_COUNT      = 3'd5;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_EMPTY    = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

endpackage

`default_nettype wire

/* rtl/bounded_deque_with_search.sv */
// Top level: bounded deque with linear search, held in a ring memory.
//
// Usage:
//   Input channel (in_valid / in_stall, opcode, value) carries one request per
//   transfer: push front/back, pop front/back, search for a value, or count.
//   Output channel (out_valid / out_stall, status, removed_value,
//   found_position, entry_count) returns exactly one result per request.
// Sequencing (one request in flight at a time):
//   push, count : request goes to a done state, then into the output register
//   pop         : one read of the ring memory, its registered data taken in a wait state
//   search      : one stored entry is read per cycle from the single memory read
//                 port and compared in the cycle after; a hit ends the scan, and
//                 a full pass with no match gives not-found.
//   A new request is taken as soon as the result is handed to the output
//   register, even while that result still waits on out_stall.
// Reset (rst, synchronous): deque empty, head at slot 0, no result pending.
//   Memory contents are not cleared; only written slots are ever read.
// Receiver stall: the output register holds its payload; a second finished
//   result waits inside, and in_stall stays high until it can move out.
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque_with_search #(
  parameter int DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire bdqs_pkg::opcode_t opcode,
  input  wire bdqs_pkg::data_t  value,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output bdqs_pkg::status_t     status,
  output bdqs_pkg::data_t       removed_value,
  output bdqs_pkg::pos_t        found_position,
  output bdqs_pkg::pos_t        entry_count
);

  import bdqs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // ring slot index
  localparam int CW = $clog2(DEPTH + 1);                // count / offset
  localparam int SW = CW + 1;                           // head + offset sum

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_RDWAIT = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  // ring memory, one write and one registered read port
  logic [31:0]   mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   rd_data;

  // control state
  logic [1:0]    state;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] scan_k;
  logic          cmp_valid;
  logic [CW-1:0] cmp_pos;
  logic [31:0]   key;

  // pending result
  status_t       res_status;
  logic [31:0]   res_removed;
  logic [4:0]    res_pos;

  logic          in_xfer;
  logic          out_free;
  logic          full;
  logic          empty;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic [CW-1:0] slot_offs;
  logic [SW-1:0] slot_sum;
  logic [AW-1:0] slot;
  logic [31:0]   cnt_ext;
  logic [31:0]   pos_ext;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);

  // ring slot of (head + offset) mod DEPTH; sum stays below 2*DEPTH
  always_comb begin
    case (state)
      S_SCAN:  slot_offs = scan_k;
      default: begin
        if (opcode == OP_POP_BACK) begin
          slot_offs = count - CW'(1);
        end else begin
          slot_offs = count;
        end
      end
    endcase
  end

  always_comb begin
    slot_sum = SW'(head) + SW'(slot_offs);
    if (slot_sum >= SW'(DEPTH)) begin
      slot = AW'(slot_sum - SW'(DEPTH));
    end else begin
      slot = AW'(slot_sum);
    end
  end

  assign cnt_ext = 32'(count);
  assign pos_ext = 32'(cmp_pos) + 32'd1;

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot;
    mem_wdata = value;
    mem_raddr = slot;
    if (in_xfer && !full) begin
      if (opcode == OP_PUSH_FRONT) begin
        mem_we    = 1'b1;
        mem_waddr = head_dec;
      end else if (opcode == OP_PUSH_BACK) begin
        mem_we = 1'b1;
      end
    end
    if (in_xfer && opcode == OP_POP_FRONT) begin
      mem_raddr = head;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      scan_k    <= '0;
      cmp_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            res_status  <= ST_OK;
            res_removed <= '0;
            res_pos     <= '0;
            key         <= value;
            scan_k      <= '0;
            cmp_valid   <= 1'b0;
            state       <= S_DONE;
            case (opcode)
              OP_PUSH_FRONT: begin
                if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  head  <= head_dec;
                  count <= count + CW'(1);
                end
              end
              OP_PUSH_BACK: begin
                if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  count <= count + CW'(1);
                end
              end
              OP_POP_FRONT: begin
                if (empty) begin
                  res_status <= ST_EMPTY;
                end else begin
                  head  <= head_inc;
                  count <= count - CW'(1);
                  state <= S_RDWAIT;
                end
              end
              OP_POP_BACK: begin
                if (empty) begin
                  res_status <= ST_EMPTY;
                end else begin
                  count <= count - CW'(1);
                  state <= S_RDWAIT;
                end
              end
              OP_SEARCH: begin
                state <= S_SCAN;
              end
              default: begin
                // count and unused codes: no change
              end
            endcase
          end
        end
        S_RDWAIT: begin
          res_removed <= rd_data;
          state       <= S_DONE;
        end
        S_SCAN: begin
          if (cmp_valid && rd_data == key) begin
            res_pos   <= pos_ext[4:0];
            cmp_valid <= 1'b0;
            state     <= S_DONE;
          end else if (scan_k == count && !cmp_valid) begin
            res_status <= ST_NOTFOUND;
            state      <= S_DONE;
          end else if (scan_k != count) begin
            // read issued this cycle at slot(head + scan_k)
            cmp_valid <= 1'b1;
            cmp_pos   <= scan_k;
            scan_k    <= scan_k + CW'(1);
          end else begin
            cmp_valid <= 1'b0;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      status         <= res_status;
      removed_value  <= res_removed;
      found_position <= res_pos;
      entry_count    <= cnt_ext[4:0];
    end
  end

endmodule

`default_nettype wire
